// ===== sv/cmpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmpc_pkg
// Shared constants, types and the arctangent table for the compass heading
// pipeline.
// ----------------------------------------------------------------------------
package cmpc_pkg;

  localparam int SAMPLE_BITS_DEF  = 12;
  localparam int CORDIC_STEPS_DEF = 16;

  // Fraction bits of the fixed-point vector and angle words.
  localparam int FRAC_BITS  = 16;
  // Headroom above the scaled sample for the quadrant turn and CORDIC gain.
  localparam int GUARD_BITS = 3;

  // Angle accumulator: hundredths of a degree times 2^16.
  localparam int ACC_W = 33;
  localparam int RAW_W = ACC_W - FRAC_BITS;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int HEAD_W     = 16;
  localparam int CARD_W     = 2;

  // Width of the summed heading before the wrap, and of its biased form.
  localparam int SUMX_W = 20;
  localparam int SUM_W  = 18;

  localparam logic [CFG_ADDR_W-1:0] REG_DECLINATION = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MOUNT       = 2'd1;

  localparam logic [CFG_DATA_W-1:0] DECLINATION_RST = 16'd201;
  localparam logic [CFG_DATA_W-1:0] MOUNT_RST       = 16'd9000;

  localparam logic signed [ACC_W-1:0] QUARTER_ACC = 33'sd589824000;
  localparam logic signed [ACC_W-1:0] ROUND_HALF  = 33'sd32768;

  // Four full turns lift every possible sum above zero before the wrap.
  localparam logic signed [SUMX_W-1:0] WRAP_BIAS = 20'sd144000;
  localparam logic [SUM_W-1:0] TURN_1 = 18'd36000;
  localparam logic [SUM_W-1:0] TURN_2 = 18'd72000;
  localparam logic [SUM_W-1:0] TURN_3 = 18'd108000;
  localparam logic [SUM_W-1:0] TURN_4 = 18'd144000;
  localparam logic [SUM_W-1:0] TURN_5 = 18'd180000;

  localparam logic [HEAD_W-1:0] FULL_TURN  = 16'd36000;
  localparam logic [HEAD_W-1:0] BOUND_EAST  = 16'd4500;
  localparam logic [HEAD_W-1:0] BOUND_SOUTH = 16'd13500;
  localparam logic [HEAD_W-1:0] BOUND_WEST  = 16'd22500;
  localparam logic [HEAD_W-1:0] BOUND_NORTH = 16'd31500;

  typedef enum logic [CARD_W-1:0] {
    CARD_NORTH = 2'd0,
    CARD_EAST  = 2'd1,
    CARD_SOUTH = 2'd2,
    CARD_WEST  = 2'd3
  } cardinal_t;

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    logic valid;
    logic zero;
  } stage_ctl_t;

  // round(atan(2^-i) in degrees * 100 * 2^16)
  function automatic logic signed [ACC_W-1:0] atan_entry(input int unsigned idx);
    case (idx)
      0:       return 33'sd294912000;
      1:       return 33'sd174096719;
      2:       return 33'sd91987925;
      3:       return 33'sd46694507;
      4:       return 33'sd23437865;
      5:       return 33'sd11730358;
      6:       return 33'sd5866610;
      7:       return 33'sd2933484;
      8:       return 33'sd1466764;
      9:       return 33'sd733385;
      10:      return 33'sd366693;
      11:      return 33'sd183346;
      12:      return 33'sd91673;
      13:      return 33'sd45837;
      14:      return 33'sd22918;
      15:      return 33'sd11459;
      16:      return 33'sd5730;
      17:      return 33'sd2865;
      18:      return 33'sd1432;
      19:      return 33'sd716;
      20:      return 33'sd358;
      21:      return 33'sd179;
      22:      return 33'sd90;
      23:      return 33'sd45;
      default: return '0;
    endcase
  endfunction

endpackage

// ===== sv/compass_heading_from_field.sv =====
// ----------------------------------------------------------------------------
// compass_heading_from_field
// Compass heading and cardinal bin from one x/y magnetometer sample, using a
// pipelined CORDIC for atan2 followed by offset, wrap and binning stages.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Words
//   --------  ---------------------  ------------------------------------
//   in        in_valid / in_ready    field_x, field_y
//   out       out_valid / out_ready  heading_centideg, cardinal
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// A word passes through one input stage, one stage per CORDIC iteration,
// then sum, wrap and output stages. A new word is taken every cycle while
// the output drains.
// Reset clears every stage valid bit and loads declination 201, offset 9000.
// Each stage holds only while the stage after it is full and stalled, so
// bubbles close up and a stall neither drops nor repeats a word.
//
module compass_heading_from_field #(
  parameter int CORDIC_STEPS = cmpc_pkg::CORDIC_STEPS_DEF,
  parameter int SAMPLE_BITS  = cmpc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     field_x,
  input  logic signed [SAMPLE_BITS-1:0]     field_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cmpc_pkg::HEAD_W-1:0]       heading_centideg,
  output logic [cmpc_pkg::CARD_W-1:0]       cardinal,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cmpc_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [cmpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cmpc_pkg::*;

  localparam int W = SAMPLE_BITS + FRAC_BITS + GUARD_BITS;

  logic [CFG_DATA_W-1:0] declination;
  logic [CFG_DATA_W-1:0] mount_offset;

  stage_ctl_t              ctl_s [CORDIC_STEPS+1];
  logic                    rdy_s [CORDIC_STEPS+1];
  logic signed [W-1:0]     x_s   [CORDIC_STEPS+1];
  logic signed [W-1:0]     y_s   [CORDIC_STEPS+1];
  logic signed [ACC_W-1:0] acc_s [CORDIC_STEPS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      declination  <= DECLINATION_RST;
      mount_offset <= MOUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DECLINATION: declination  <= cfg_data;
        REG_MOUNT:       mount_offset <= cfg_data;
        default:         ;
      endcase
    end
  end

  cmpc_prerot #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_prerot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .field_x   (field_x),
    .field_y   (field_y),
    .ctl       (ctl_s[0]),
    .out_ready (rdy_s[0]),
    .x         (x_s[0]),
    .y         (y_s[0]),
    .acc       (acc_s[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    cmpc_cordic_stage #(
      .W     (W),
      .SHIFT (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_ctl    (ctl_s[i]),
      .in_ready  (rdy_s[i]),
      .in_x      (x_s[i]),
      .in_y      (y_s[i]),
      .in_acc    (acc_s[i]),
      .ctl       (ctl_s[i+1]),
      .out_ready (rdy_s[i+1]),
      .x         (x_s[i+1]),
      .y         (y_s[i+1]),
      .acc       (acc_s[i+1])
    );
  end

  cmpc_post u_post (
    .clk              (clk),
    .rst              (rst),
    .in_ctl           (ctl_s[CORDIC_STEPS]),
    .in_ready         (rdy_s[CORDIC_STEPS]),
    .in_acc           (acc_s[CORDIC_STEPS]),
    .declination      (declination),
    .mount_offset     (mount_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .heading_centideg (heading_centideg),
    .cardinal         (cardinal)
  );

endmodule

// ===== sv/cmpc_prerot.sv =====
// ----------------------------------------------------------------------------
// cmpc_prerot
// Input stage: scales the sample, turns left half-plane vectors into the
// right half-plane and seeds the angle accumulator.
// ----------------------------------------------------------------------------
module cmpc_prerot #(
  parameter int SAMPLE_BITS = cmpc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   in_valid,
  output logic                                                   in_ready,
  input  logic signed [SAMPLE_BITS-1:0]                          field_x,
  input  logic signed [SAMPLE_BITS-1:0]                          field_y,
  output cmpc_pkg::stage_ctl_t                                   ctl,
  input  logic                                                   out_ready,
  output logic signed [SAMPLE_BITS+cmpc_pkg::FRAC_BITS+cmpc_pkg::GUARD_BITS-1:0] x,
  output logic signed [SAMPLE_BITS+cmpc_pkg::FRAC_BITS+cmpc_pkg::GUARD_BITS-1:0] y,
  output logic signed [cmpc_pkg::ACC_W-1:0]                      acc
);
  import cmpc_pkg::*;

  localparam int W = SAMPLE_BITS + FRAC_BITS + GUARD_BITS;

  logic signed [W-1:0]     x0;
  logic signed [W-1:0]     y0;
  logic signed [W-1:0]     x_next;
  logic signed [W-1:0]     y_next;
  logic signed [ACC_W-1:0] acc_next;
  logic                    zero_next;

  assign x0 = {{GUARD_BITS{field_x[SAMPLE_BITS-1]}}, field_x, {FRAC_BITS{1'b0}}};
  assign y0 = {{GUARD_BITS{field_y[SAMPLE_BITS-1]}}, field_y, {FRAC_BITS{1'b0}}};

  always_comb begin
    zero_next = (field_x == '0) && (field_y == '0);
    x_next    = x0;
    y_next    = y0;
    acc_next  = '0;
    if (x0[W-1]) begin
      if (!y0[W-1]) begin
        x_next   = y0;
        y_next   = -x0;
        acc_next = QUARTER_ACC;
      end else begin
        x_next   = -y0;
        y_next   = x0;
        acc_next = -QUARTER_ACC;
      end
    end
  end

  assign in_ready = !ctl.valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (in_ready) begin
      ctl.valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      ctl.zero <= zero_next;
      x        <= x_next;
      y        <= y_next;
      acc      <= acc_next;
    end
  end

endmodule

// ===== sv/cmpc_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// cmpc_cordic_stage
// One registered CORDIC vectoring iteration with a fixed shift.
// ----------------------------------------------------------------------------
module cmpc_cordic_stage #(
  parameter int W     = cmpc_pkg::SAMPLE_BITS_DEF + cmpc_pkg::FRAC_BITS +
                        cmpc_pkg::GUARD_BITS,
  parameter int SHIFT = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cmpc_pkg::stage_ctl_t              in_ctl,
  output logic                              in_ready,
  input  logic signed [W-1:0]               in_x,
  input  logic signed [W-1:0]               in_y,
  input  logic signed [cmpc_pkg::ACC_W-1:0] in_acc,
  output cmpc_pkg::stage_ctl_t              ctl,
  input  logic                              out_ready,
  output logic signed [W-1:0]               x,
  output logic signed [W-1:0]               y,
  output logic signed [cmpc_pkg::ACC_W-1:0] acc
);
  import cmpc_pkg::*;

  localparam logic signed [ACC_W-1:0] STEP_ANGLE = atan_entry(SHIFT);

  logic signed [W-1:0]     xs;
  logic signed [W-1:0]     ys;
  logic signed [W-1:0]     x_next;
  logic signed [W-1:0]     y_next;
  logic signed [ACC_W-1:0] acc_next;

  assign xs = in_x >>> SHIFT;
  assign ys = in_y >>> SHIFT;

  // Rotate toward the positive x axis; the sign of y picks the direction.
  always_comb begin
    if (!in_y[W-1]) begin
      x_next   = in_x + ys;
      y_next   = in_y - xs;
      acc_next = in_acc + STEP_ANGLE;
    end else begin
      x_next   = in_x - ys;
      y_next   = in_y + xs;
      acc_next = in_acc - STEP_ANGLE;
    end
  end

  assign in_ready = !ctl.valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (in_ready) begin
      ctl.valid <= in_ctl.valid;
    end
    if (in_ready && in_ctl.valid) begin
      ctl.zero <= in_ctl.zero;
      x        <= x_next;
      y        <= y_next;
      acc      <= acc_next;
    end
  end

endmodule

// ===== sv/cmpc_post.sv =====
// ----------------------------------------------------------------------------
// cmpc_post
// Back end: rounds the angle, applies declination and mounting offset,
// wraps into one turn and sorts the heading into a cardinal bin.
// ----------------------------------------------------------------------------
module cmpc_post (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cmpc_pkg::stage_ctl_t                  in_ctl,
  output logic                                  in_ready,
  input  logic signed [cmpc_pkg::ACC_W-1:0]     in_acc,
  input  logic [cmpc_pkg::CFG_DATA_W-1:0]       declination,
  input  logic [cmpc_pkg::CFG_DATA_W-1:0]       mount_offset,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [cmpc_pkg::HEAD_W-1:0]           heading_centideg,
  output logic [cmpc_pkg::CARD_W-1:0]           cardinal
);
  import cmpc_pkg::*;

  logic                    sum_valid;
  logic                    wrap_valid;
  logic                    sum_ready;
  logic                    wrap_ready;
  logic                    out_stage_ready;
  logic [SUM_W-1:0]        biased;
  logic [SUM_W-1:0]        biased_next;
  logic [HEAD_W-1:0]       wrapped;
  logic [HEAD_W-1:0]       wrapped_next;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [RAW_W-1:0] raw;
  logic signed [SUMX_W-1:0] sum_full;
  logic [SUM_W-1:0]        turn_sub;
  logic [SUM_W-1:0]        diff;
  cardinal_t               cardinal_next;

  assign out_stage_ready = !out_valid || out_ready;
  assign wrap_ready      = !wrap_valid || out_stage_ready;
  assign sum_ready       = !sum_valid || wrap_ready;
  assign in_ready        = sum_ready;

  // Round half up (zero for a zero vector), add declination, subtract the mounting offset and add the wrap bias.
  always_comb begin
    acc_rnd     = in_acc + ROUND_HALF;
    raw         = in_ctl.zero ? '0 : acc_rnd[ACC_W-1:FRAC_BITS];
    sum_full    = {{(SUMX_W-RAW_W){raw[RAW_W-1]}}, raw}
                + {{(SUMX_W-CFG_DATA_W){declination[CFG_DATA_W-1]}}, declination}
                - {{(SUMX_W-CFG_DATA_W){1'b0}}, mount_offset}
                + WRAP_BIAS;
    biased_next = sum_full[SUM_W-1:0];
  end

  // The biased sum lies between zero and six turns: take off whole turns.
  always_comb begin
    if (biased >= TURN_5) begin
      turn_sub = TURN_5;
    end else if (biased >= TURN_4) begin
      turn_sub = TURN_4;
    end else if (biased >= TURN_3) begin
      turn_sub = TURN_3;
    end else if (biased >= TURN_2) begin
      turn_sub = TURN_2;
    end else if (biased >= TURN_1) begin
      turn_sub = TURN_1;
    end else begin
      turn_sub = '0;
    end
    diff         = biased - turn_sub;
    wrapped_next = diff[HEAD_W-1:0];
  end

  always_comb begin
    if (wrapped < BOUND_EAST) begin
      cardinal_next = CARD_NORTH;
    end else if (wrapped < BOUND_SOUTH) begin
      cardinal_next = CARD_EAST;
    end else if (wrapped < BOUND_WEST) begin
      cardinal_next = CARD_SOUTH;
    end else if (wrapped < BOUND_NORTH) begin
      cardinal_next = CARD_WEST;
    end else begin
      cardinal_next = CARD_NORTH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid  <= 1'b0;
      wrap_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (sum_ready) begin
        sum_valid <= in_ctl.valid;
      end
      if (wrap_ready) begin
        wrap_valid <= sum_valid;
      end
      if (out_stage_ready) begin
        out_valid <= wrap_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && in_ctl.valid) begin
      biased <= biased_next;
    end
    if (wrap_ready && sum_valid) begin
      wrapped <= wrapped_next;
    end
    if (out_stage_ready && wrap_valid) begin
      heading_centideg <= wrapped;
      cardinal         <= cardinal_next;
    end
  end

endmodule

// ===== sv/cmpc_checker.sv =====
// ----------------------------------------------------------------------------
// cmpc_checker
// Port-level checks on the heading output, bound to the top level.
// ----------------------------------------------------------------------------
module cmpc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cmpc_pkg::HEAD_W-1:0] heading_centideg,
  input logic [cmpc_pkg::CARD_W-1:0] cardinal
);
  import cmpc_pkg::*;

  // The output stage comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> heading_centideg < FULL_TURN)
    else $error("heading outside one turn");

  // The bin must agree with the heading it was sorted from.
  a_cardinal_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((cardinal == CARD_NORTH) &&
         (heading_centideg < BOUND_EAST || heading_centideg >= BOUND_NORTH)) ||
      ((cardinal == CARD_EAST) &&
         heading_centideg >= BOUND_EAST && heading_centideg < BOUND_SOUTH) ||
      ((cardinal == CARD_SOUTH) &&
         heading_centideg >= BOUND_SOUTH && heading_centideg < BOUND_WEST) ||
      ((cardinal == CARD_WEST) &&
         heading_centideg >= BOUND_WEST && heading_centideg < BOUND_NORTH))
    else $error("cardinal bin does not match heading");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(heading_centideg) && $stable(cardinal))
    else $error("stalled output word changed");

endmodule

bind compass_heading_from_field cmpc_checker u_cmpc_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .heading_centideg (heading_centideg),
  .cardinal         (cardinal)
);
